// File: sv/vid_pkg.sv
// Shared types and constants for the varint instruction decoder.
// Used by the decoder top level and its port checker; no dependencies.
package vid_pkg;

	localparam int WORD_BITS_DEF = 32;

	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;
	localparam int KIND_W  = 2;

	// tdata carries value then byte_count, padded to whole bytes
	localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_NUMBER = 2'd0;
	localparam kind_t KIND_ACTION = 2'd1;
	localparam kind_t KIND_FAULT  = 2'd2;

	// top two bits of an instruction byte
	localparam logic [1:0] TAG_CONT   = 2'b01;
	localparam logic [1:0] TAG_ACTION = 2'b10;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

endpackage

// File: sv/varint_instruction_decoder.sv
// Varint decoder: one byte in per cycle unless stalled, one result per instruction.
// Depends on vid_pkg for kinds, tags and field widths.
//
// Takes one stream byte per cycle, with no bubbles unless the output stalls. A byte
// passes an input register, then one pass of mask, shift-or and sign-extend logic
// against the running accumulator, then a result register, from which the item of
// a final byte is sent. Continuation bytes (tag 01) give no item. A finished item
// waiting on the output stalls the input only once the input register also holds
// a final byte; s_axis_tready then follows m_axis_tready in the same cycle.
module varint_instruction_decoder #(
	parameter int WORD_BITS = vid_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [vid_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                          s_axis_tuser,  // [0] load_fault
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [vid_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [31:0] value, [37:32] byte_count
	output logic [vid_pkg::KIND_W-1:0]    m_axis_tuser   // [1:0] kind
);
	import vid_pkg::*;

	localparam int PW = $clog2(WORD_BITS + 1);
	localparam int IW = $clog2(WORD_BITS);
	localparam logic [PW:0] WORD_L = (PW + 1)'(WORD_BITS);

	// input stage
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              fault_s1;

	// instruction state
	logic [WORD_BITS-1:0] acc_q;
	logic [PW-1:0]        pos_q;
	logic [COUNT_W-1:0]   cnt_q;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;
	kind_t              kind_q;

	logic [1:0]           tag;
	logic                 is_cont;
	logic                 has_result;
	logic                 adv_s1;
	logic [BYTE_W-1:0]    payload;
	logic [WORD_BITS-1:0] placed;
	logic [PW:0]          top;
	logic [PW:0]          top_m1;
	logic                 sign_bit;
	logic [WORD_BITS-1:0] ext_mask;
	logic [WORD_BITS-1:0] word_num;
	logic [PW:0]          pos6;
	logic [PW-1:0]        pos_next;
	logic [COUNT_W-1:0]   cnt_inc;
	kind_t                kind_d;
	logic [VALUE_W-1:0]   value_d;

	always_comb begin
		tag        = byte_s1[7:6];
		is_cont    = !fault_s1 && (tag == TAG_CONT);
		has_result = v_s1 && !is_cont;
		adv_s1     = !has_result || !out_valid_q || m_axis_tready;

		// actions and continuations carry six payload bits, numbers all eight
		payload = (tag == TAG_CONT || tag == TAG_ACTION) ? {2'b00, byte_s1[5:0]} : byte_s1;
		if ((PW + 1)'(pos_q) < WORD_L) begin
			placed = acc_q | (WORD_BITS'(payload) << pos_q);
		end else begin
			placed = acc_q;
		end

		top      = (PW + 1)'(pos_q) + (PW + 1)'(8);
		top_m1   = top - (PW + 1)'(1);
		sign_bit = 1'b0;
		ext_mask = '0;
		if (top < WORD_L) begin
			sign_bit = placed[top_m1[IW-1:0]];
			ext_mask = ~((WORD_BITS'(1) << top) - WORD_BITS'(1));
		end
		word_num = sign_bit ? (placed | ext_mask) : placed;

		pos6     = (PW + 1)'(pos_q) + (PW + 1)'(6);
		pos_next = (pos6 > WORD_L) ? WORD_L[PW-1:0] : pos6[PW-1:0];
		cnt_inc  = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + COUNT_W'(1);

		if (fault_s1) begin
			kind_d  = KIND_FAULT;
			value_d = '0;
		end else if (tag == TAG_ACTION) begin
			kind_d  = KIND_ACTION;
			value_d = VALUE_W'(placed);
		end else begin
			kind_d  = KIND_NUMBER;
			value_d = VALUE_W'($signed(word_num));
		end
	end

	assign s_axis_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			fault_s1 <= s_axis_tuser;
		end
	end

	// advance the accumulator on continuations, clear it once an item ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else if (v_s1 && adv_s1) begin
			if (is_cont) begin
				acc_q <= placed;
				pos_q <= pos_next;
				cnt_q <= cnt_inc;
			end else begin
				acc_q <= '0;
				pos_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (has_result && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (has_result && adv_s1) begin
			value_q <= value_d;
			count_q <= cnt_inc;
			kind_q  <= kind_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), count_q, value_q};
	assign m_axis_tuser  = kind_q;

endmodule

// File: sv/vid_checker.sv
// Port-level checks for the varint instruction decoder, bound to its top level.
// Depends on vid_pkg for kinds and field widths.
module vid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [vid_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [vid_pkg::KIND_W-1:0]     m_axis_tuser
);
	import vid_pkg::*;

	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] count;

	assign value = m_axis_tdata[VALUE_W-1:0];
	assign count = m_axis_tdata[VALUE_W +: COUNT_W];

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_FAULT |-> value == '0)
		else $error("fault item with nonzero value");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> count != '0)
		else $error("item with zero byte count");

	// a one-byte action holds only its six payload bits
	a_short_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ACTION && count == COUNT_W'(1)
			|-> value[VALUE_W-1:6] == '0)
		else $error("one-byte action wider than six bits");

	// a one-byte number is the sign extension of its byte
	a_short_number: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_NUMBER && count == COUNT_W'(1)
			|-> value[VALUE_W-1:7] == '0 || value[VALUE_W-1:7] == '1)
		else $error("one-byte number not sign-extended");

endmodule

bind varint_instruction_decoder vid_checker u_vid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
